### hdl/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// rhsv_pkg
// Types and constants shared by the RGB to HSV pixel pipeline.
// ----------------------------------------------------------------------------
package rhsv_pkg;

   localparam int CHAN_W  = 8;            // colour channel width
   localparam int HUE_W   = 15;           // hue field width
   localparam int HQUO_W  = 12;           // hue quotient bits, max 3840
   localparam int SQUO_W  = 8;            // saturation quotient bits, max 255
   localparam int HNUM_W  = 20;           // 3840 * 255 fits
   localparam int SNUM_W  = 16;           // 255 * 255 fits
   localparam int SUM_W   = HUE_W + 1;    // signed hue before wrap

   localparam int HUE_SECTOR = 3840;      // 60 degrees in 1/64 degree
   localparam int FULL_SCALE = 255;

   localparam logic [HUE_W-1:0] HUE_RED   = HUE_W'(0);
   localparam logic [HUE_W-1:0] HUE_GREEN = HUE_W'(7680);
   localparam logic [HUE_W-1:0] HUE_BLUE  = HUE_W'(15360);
   localparam logic [HUE_W-1:0] HUE_FULL  = HUE_W'(23040);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rhsv_req_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } rhsv_rsp_type;

   // after max/min and sector selection
   typedef struct packed {
      logic              grey;
      logic              neg;
      logic [HUE_W-1:0]  base;
      logic [CHAN_W-1:0] hi;
      logic [CHAN_W-1:0] delta;
      logic [CHAN_W-1:0] mag;
   } rhsv_sect_type;

   // carried through the divider stages
   typedef struct packed {
      logic              grey;
      logic              neg;
      logic [HUE_W-1:0]  base;
      logic [CHAN_W-1:0] hi;
      logic [CHAN_W-1:0] delta;
      logic [HNUM_W-1:0] hrem;
      logic [SNUM_W-1:0] srem;
      logic [HQUO_W-1:0] hquo;
      logic [SQUO_W-1:0] squo;
   } rhsv_div_type;

endpackage

### hdl/rhsv_front.sv
// ----------------------------------------------------------------------------
// rhsv_front
// Two stages: max/min and sector pick, then the dividend products.
// ----------------------------------------------------------------------------
module rhsv_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  rhsv_pkg::rhsv_req_type in_data,
   output logic                  out_vld,
   output rhsv_pkg::rhsv_div_type out_data
);

   logic                    vld1_ff;
   rhsv_pkg::rhsv_sect_type sect_ff, sect_in;
   logic                    vld2_ff;
   rhsv_pkg::rhsv_div_type  div_ff, div_in;

   logic [rhsv_pkg::CHAN_W-1:0] hi, lo;
   logic signed [rhsv_pkg::CHAN_W:0] diff;

   always_comb begin
      hi = (in_data.red > in_data.green) ? in_data.red : in_data.green;
      hi = (hi > in_data.blue) ? hi : in_data.blue;
      lo = (in_data.red < in_data.green) ? in_data.red : in_data.green;
      lo = (lo < in_data.blue) ? lo : in_data.blue;

      // ties go to red, then green
      if (hi == in_data.red) begin
         diff          = signed'({1'b0, in_data.green}) - signed'({1'b0, in_data.blue});
         sect_in.base  = rhsv_pkg::HUE_RED;
      end else if (hi == in_data.green) begin
         diff          = signed'({1'b0, in_data.blue}) - signed'({1'b0, in_data.red});
         sect_in.base  = rhsv_pkg::HUE_GREEN;
      end else begin
         diff          = signed'({1'b0, in_data.red}) - signed'({1'b0, in_data.green});
         sect_in.base  = rhsv_pkg::HUE_BLUE;
      end

      sect_in.hi    = hi;
      sect_in.delta = hi - lo;
      sect_in.grey  = (hi == lo);
      sect_in.neg   = diff[rhsv_pkg::CHAN_W];
      sect_in.mag   = diff[rhsv_pkg::CHAN_W] ? rhsv_pkg::CHAN_W'(-diff)
                                             : rhsv_pkg::CHAN_W'(diff);
   end

   always_comb begin
      div_in.grey  = sect_ff.grey;
      div_in.neg   = sect_ff.neg;
      div_in.base  = sect_ff.base;
      div_in.hi    = sect_ff.hi;
      div_in.delta = sect_ff.delta;
      div_in.hrem  = rhsv_pkg::HNUM_W'(sect_ff.mag)
                   * rhsv_pkg::HNUM_W'(rhsv_pkg::HUE_SECTOR);
      div_in.srem  = rhsv_pkg::SNUM_W'(sect_ff.delta)
                   * rhsv_pkg::SNUM_W'(rhsv_pkg::FULL_SCALE);
      div_in.hquo  = '0;
      div_in.squo  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sect_ff <= sect_in;
         div_ff  <= div_in;
      end
   end

   assign out_vld  = vld2_ff;
   assign out_data = div_ff;

endmodule

### hdl/rhsv_div_pipe.sv
// ----------------------------------------------------------------------------
// rhsv_div_pipe
// Restoring division, a hue bit per stage; saturation in the last SQUO_W.
// ----------------------------------------------------------------------------
module rhsv_div_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  rhsv_pkg::rhsv_div_type in_data,
   output logic                  out_vld,
   output rhsv_pkg::rhsv_div_type out_data
);

   localparam int STAGES = rhsv_pkg::HQUO_W;

   logic                   vld_ff   [STAGES];
   rhsv_pkg::rhsv_div_type stage_ff [STAGES];
   rhsv_pkg::rhsv_div_type stage_in [STAGES];

   genvar s;
   generate
      for (s = 0; s < STAGES; s++) begin : g_stage
         localparam int K = STAGES - 1 - s;   // quotient bit settled here
         rhsv_pkg::rhsv_div_type cur;
         logic [rhsv_pkg::HNUM_W-1:0] hcmp;

         if (s == 0) begin : g_first
            assign cur = in_data;
         end else begin : g_next
            assign cur = stage_ff[s-1];
         end

         assign hcmp = rhsv_pkg::HNUM_W'(cur.delta) << K;

         if (K < rhsv_pkg::SQUO_W) begin : g_both
            logic [rhsv_pkg::SNUM_W-1:0] scmp;
            assign scmp = rhsv_pkg::SNUM_W'(cur.hi) << K;
            always_comb begin
               stage_in[s] = cur;
               if (cur.hrem >= hcmp) begin
                  stage_in[s].hrem    = cur.hrem - hcmp;
                  stage_in[s].hquo[K] = 1'b1;
               end
               if (cur.srem >= scmp) begin
                  stage_in[s].srem    = cur.srem - scmp;
                  stage_in[s].squo[K] = 1'b1;
               end
            end
         end else begin : g_hue
            always_comb begin
               stage_in[s] = cur;
               if (cur.hrem >= hcmp) begin
                  stage_in[s].hrem    = cur.hrem - hcmp;
                  stage_in[s].hquo[K] = 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else if (adv) begin
               vld_ff[s] <= (s == 0) ? in_vld : vld_ff[(s == 0) ? 0 : s-1];
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               stage_ff[s] <= stage_in[s];
            end
         end
      end
   endgenerate

   assign out_vld  = vld_ff[STAGES-1];
   assign out_data = stage_ff[STAGES-1];

endmodule

### hdl/rhsv_back.sv
// ----------------------------------------------------------------------------
// rhsv_back
// Applies sign and sector base, wraps hue, and holds the output register.
// ----------------------------------------------------------------------------
module rhsv_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  rhsv_pkg::rhsv_div_type in_data,
   output logic                  out_vld,
   output rhsv_pkg::rhsv_rsp_type out_data
);

   logic                   vld_ff;
   rhsv_pkg::rhsv_rsp_type rsp_ff, rsp_in;

   logic signed [rhsv_pkg::SUM_W-1:0] quo, hsum;

   always_comb begin
      quo  = signed'(rhsv_pkg::SUM_W'(in_data.hquo));
      hsum = signed'({1'b0, in_data.base}) + (in_data.neg ? -quo : quo);
      if (hsum < 0) begin
         hsum = hsum + signed'({1'b0, rhsv_pkg::HUE_FULL});
      end

      rsp_in.brightness = in_data.hi;
      if (in_data.grey) begin
         rsp_in.hue        = '0;
         rsp_in.saturation = '0;
      end else begin
         rsp_in.hue        = hsum[rhsv_pkg::HUE_W-1:0];
         rsp_in.saturation = in_data.squo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = rsp_ff;

endmodule

### hdl/rgb_to_hsv_pixel.sv
// 15 register stages; each req transfer passes through all of them to rsp_valid.
// Throughput: one pixel per cycle unless stalled; stage registers move as one.
// A stall on rsp_ready freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active high) clears all stage valid bits; data is unreset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// 8-bit RGB pixel to hue (1/64 degree), saturation and value.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rhsv_pkg::rhsv_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rhsv_pkg::rhsv_rsp_type rsp_data
);

   // Pipeline map:
   //   front  : 2 stages - max/min/sector, then dividends 3840*|diff|, 255*delta
   //   divider: 12 stages - hue quotient over delta, saturation over max
   //            (saturation only needs the last 8 steps)
   //   back   : 1 stage  - signed hue plus base, wrap by 360 degrees; output reg

   logic                   adv;
   logic                   front_vld, div_vld;
   rhsv_pkg::rhsv_div_type front_data, div_data;

   // Whole pipe moves together; it only holds while a result waits untaken.
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   rhsv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (req_valid),
      .in_data  (req_data),
      .out_vld  (front_vld),
      .out_data (front_data)
   );

   rhsv_div_pipe u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (front_vld),
      .in_data  (front_data),
      .out_vld  (div_vld),
      .out_data (div_data)
   );

   rhsv_back u_back (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (div_vld),
      .in_data  (div_data),
      .out_vld  (rsp_valid),
      .out_data (rsp_data)
   );

   // hue always wrapped into one turn
   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hue < rhsv_pkg::HUE_FULL))
      else $error("hue out of range");

   // zero saturation only for grey pixels, which carry zero hue
   a_grey_hue : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturation == '0) |-> (rsp_data.hue == '0))
      else $error("grey pixel with non-zero hue");

   // black pixel has no saturation
   a_black : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.brightness == '0) |-> (rsp_data.saturation == '0))
      else $error("black pixel with saturation");

endmodule
